// ===== hdl/luc_pkg.sv =====
// Shared types, codes and constants for the LRU tag cache with statistics.
package luc_pkg;

  localparam int KEY_W            = 32;
  localparam int OCC_W            = 7;
  localparam int DEFAULT_CAPACITY = 64;

  // Command codes of an input item
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Contents of one directory slot
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] stamp;
    logic [KEY_W-1:0] uses;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } luc_state_e;

endpackage

// ===== hdl/lru_tag_cache_with_stats_core.sv =====
// Top level of the fully associative LRU tag cache with hit, miss and eviction statistics.
//
// The directory is a ring of CAPACITY identical cells. A lookup item rotates the ring
// once all the way around: in each cycle the slot in cell 0 passes the head logic, which
// checks it for the key, notes the first free slot and the oldest timestamp (strictly
// smaller wins, so ties go to the lowest slot), refreshes a hit in flight, and hands the
// slot to the last cell. After a full turn every slot is back in place. The insert of
// a miss is parked in a pending write that lands when its slot passes the head during the
// next lookup, so each lookup costs exactly one turn of the ring. A lookup item passes
// through accept, one step per slot and result; a clear item goes straight from accept to
// result and empties all cells at once, keeping the hit, miss and eviction counters. The
// next item is accepted as soon as the result sits in the output register, even while
// that result waits to be taken. evicted_key is zero unless evicted is set; occupancy is
// the low 7 bits of the entry count.
module lru_tag_cache_with_stats_core
  import luc_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  logic [KEY_W-1:0] lookup_key_i,
  input  logic [KEY_W-1:0] now_tick_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             hit_o,
  output logic             evicted_o,
  output logic [KEY_W-1:0] evicted_key_o,
  output logic [KEY_W-1:0] use_count_o,
  output logic [KEY_W-1:0] hit_count_o,
  output logic [KEY_W-1:0] miss_count_o,
  output logic [KEY_W-1:0] eviction_count_o,
  output logic [OCC_W-1:0] occupancy_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  luc_state_e state_q, state_d;

  // Ring of cells
  slot_t ring[CAPACITY];
  slot_t head_wb;
  logic  ring_shift;
  logic  ring_clear;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t cell_in;
    if (i == CAPACITY - 1) begin : g_tail
      assign cell_in = head_wb;
    end else begin : g_body
      assign cell_in = ring[i+1];
    end
    luc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring_shift),
      .clear_i (ring_clear),
      .slot_i  (cell_in),
      .slot_o  (ring[i])
    );
  end

  // Item being worked on
  logic             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] now_q;
  logic [IDX_W-1:0] step_q;

  // Scan results
  logic             found_q;
  logic [KEY_W-1:0] hit_uses_q;
  logic             free_found_q;
  logic [IDX_W-1:0] free_idx_q;
  logic [KEY_W-1:0] old_stamp_q;
  logic [IDX_W-1:0] old_idx_q;
  logic [KEY_W-1:0] old_key_q;

  // Deferred insert of the last miss
  logic             pend_valid_q;
  logic [IDX_W-1:0] pend_idx_q;
  slot_t            pend_slot_q;

  // Statistics
  logic [CNT_W-1:0] entry_total_q;
  logic [KEY_W-1:0] hits_q, misses_q, evictions_q;

  // Output register
  logic             out_valid_q;
  logic             hit_q, evicted_q;
  logic [KEY_W-1:0] evicted_key_q, use_count_q;
  logic [OCC_W-1:0] occupancy_q;

  // Control
  logic in_accept;
  logic res_load;
  logic scan_last;

  // Head logic
  slot_t eff;
  logic  match;
  logic  take_free;
  logic  take_old;

  // Result of the finished item
  logic             is_clear;
  logic             res_hit, res_miss, res_ev;
  logic [KEY_W-1:0] res_ev_key, res_uses;
  logic [CNT_W-1:0] entry_total_d;
  logic [KEY_W-1:0] hits_d, misses_d, evictions_d;
  logic [IDX_W-1:0] ins_idx;
  logic [KEY_W-1:0] occ_wide;

  assign scan_last = (step_q == LAST_IDX);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and control
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ring_shift = 1'b0;
    res_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = (command_i == CMD_CLEAR) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ring_shift = 1'b1;
        if (scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_accept  = in_valid_i && in_ready_o;
  assign is_clear   = (cmd_q == CMD_CLEAR);
  assign ring_clear = res_load && is_clear;

  // Head: land a pending insert, then test the slot and refresh it on a hit
  always_comb begin
    eff = ring[0];
    if (pend_valid_q && (pend_idx_q == step_q)) begin
      eff = pend_slot_q;
    end
    match     = eff.valid && (eff.key == key_q);
    take_free = !eff.valid && !free_found_q;
    take_old  = (step_q == '0) || (eff.stamp < old_stamp_q);
    head_wb   = eff;
    if (match) begin
      head_wb.stamp = now_q;
      head_wb.uses  = eff.uses + KEY_W'(1);
    end
  end

  // Result of the finished item
  always_comb begin
    res_hit    = !is_clear && found_q;
    res_miss   = !is_clear && !found_q;
    res_ev     = res_miss && !free_found_q;
    res_ev_key = res_ev ? old_key_q : '0;
    if (is_clear) begin
      res_uses = '0;
    end else if (found_q) begin
      res_uses = hit_uses_q;
    end else begin
      res_uses = KEY_W'(1);
    end
    if (is_clear) begin
      entry_total_d = '0;
    end else if (res_miss && free_found_q) begin
      entry_total_d = entry_total_q + CNT_W'(1);
    end else begin
      entry_total_d = entry_total_q;
    end
    hits_d      = hits_q + KEY_W'(res_hit);
    misses_d    = misses_q + KEY_W'(res_miss);
    evictions_d = evictions_q + KEY_W'(res_ev);
    ins_idx     = free_found_q ? free_idx_q : old_idx_q;
    occ_wide    = KEY_W'(entry_total_d);
  end

  // Item capture and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= command_i;
      key_q <= lookup_key_i;
      now_q <= now_tick_i;
    end
    if (state_q == ST_SCAN) begin
      if (match) begin
        hit_uses_q <= head_wb.uses;
      end
      if (take_free) begin
        free_idx_q <= step_q;
      end
      if (take_old) begin
        old_stamp_q <= eff.stamp;
        old_idx_q   <= step_q;
        old_key_q   <= eff.key;
      end
    end
    if (res_load && res_miss) begin
      pend_idx_q        <= ins_idx;
      pend_slot_q.valid <= 1'b1;
      pend_slot_q.key   <= key_q;
      pend_slot_q.stamp <= now_q;
      pend_slot_q.uses  <= KEY_W'(1);
    end
    if (res_load) begin
      hit_q         <= res_hit;
      evicted_q     <= res_ev;
      evicted_key_q <= res_ev_key;
      use_count_q   <= res_uses;
      occupancy_q   <= occ_wide[OCC_W-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= '0;
      found_q       <= 1'b0;
      free_found_q  <= 1'b0;
      pend_valid_q  <= 1'b0;
      entry_total_q <= '0;
      hits_q        <= '0;
      misses_q      <= '0;
      evictions_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        step_q       <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        step_q <= step_q + IDX_W'(1);
        if (match) begin
          found_q <= 1'b1;
        end
        if (take_free) begin
          free_found_q <= 1'b1;
        end
      end
      if (state_q == ST_SCAN && pend_idx_q == step_q) begin
        // the pending insert lands in its slot at this step
        pend_valid_q <= 1'b0;
      end else if (res_load) begin
        pend_valid_q <= res_miss;
      end
      if (res_load) begin
        entry_total_q <= entry_total_d;
        hits_q        <= hits_d;
        misses_q      <= misses_d;
        evictions_q   <= evictions_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign evicted_o        = evicted_q;
  assign evicted_key_o    = evicted_key_q;
  assign use_count_o      = use_count_q;
  assign hit_count_o      = hits_q;
  assign miss_count_o     = misses_q;
  assign eviction_count_o = evictions_q;
  assign occupancy_o      = occupancy_q;

  // Entry count never exceeds the ring size
  a_entry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_total_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A parked insert is gone once the scan has passed its slot
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q != ST_SCAN || step_q <= pend_idx_q))
    else $error("pending insert not landed in its turn");

  // A clear item skips the ring turn
  a_clear_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && command_i == CMD_CLEAR) |=> state_q == ST_DONE)
    else $error("clear item did not go straight to result");

  // The last slot of a turn ends the scan
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_last) |=> state_q == ST_DONE)
    else $error("scan ran past the last slot");

  // A hit and an eviction never come together
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(hit_q && evicted_q))
    else $error("hit reported with eviction");

endmodule

// ===== hdl/luc_cell.sv =====
// One slot of the rotating tag ring: holds a slot and hands it to its neighbor.
module luc_cell
  import luc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  logic  clear_i,
  input  slot_t slot_i,
  output slot_t slot_o
);

  logic       valid_q;
  slot_t      data_q;

  // valid is control state; the payload needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= slot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= slot_i;
    end
  end

  always_comb begin
    slot_o       = data_q;
    slot_o.valid = valid_q;
  end

endmodule
